>>> hw/rtl/aelr_pkg.sv
// ----------------------------------------------------------------------------
// aelr_pkg
// Shared types and constants for the enhancement-layer rewrapper.
// ----------------------------------------------------------------------------
package aelr_pkg;

  typedef enum logic [3:0] {
    S_LOAD,
    S_READ,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SCAN_END,
    S_REPORT,
    S_RD_FIND,
    S_RD_CHK,
    S_RD_EMIT
  } aelr_state_t;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_BYTE   = 1'b1;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_OVERSIZED = 2'd2;

  localparam logic [1:0] REG_DROP_TYPE  = 2'd0;
  localparam logic [1:0] REG_RPU_TYPE   = 2'd1;
  localparam logic [1:0] REG_WRAP_FIRST = 2'd2;
  localparam logic [1:0] REG_WRAP_SECND = 2'd3;

  localparam logic [5:0] DROP_TYPE_RST  = 6'd35;
  localparam logic [5:0] RPU_TYPE_RST   = 6'd62;
  localparam logic [7:0] WRAP_FIRST_RST = 8'h7e;
  localparam logic [7:0] WRAP_SECND_RST = 8'h01;

  localparam logic [2:0]  TID_MASK    = 3'h7;
  localparam logic [16:0] OUT_LEN_MAX = 17'h1ffff;
  localparam logic [8:0]  COUNT_MAX   = 9'd511;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic restart;
    logic scan_rd;
    logic scan_ev;
    logic scan_end;
    logic report;
    logic rd_chk;
    logic rd_wrap;
    logic rd_emit;
    logic out_empty;
  } aelr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fault;
    logic more;
    logic ok;
    logic ent_ok;
    logic ent_end;
    logic pass;
    logic last;
    logic out_busy;
  } aelr_sts_t;

endpackage

>>> hw/rtl/aelr_ram.sv
// ----------------------------------------------------------------------------
// aelr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aelr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/aelr_ctrl.sv
// ----------------------------------------------------------------------------
// aelr_ctrl
// Sequencer: load phase, start-code scan, status report and byte readout.
// ----------------------------------------------------------------------------
module aelr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_cmd,
  input  logic                  in_final,
  output aelr_pkg::aelr_cmd_t   cmd,
  input  aelr_pkg::aelr_sts_t   sts
);

  aelr_pkg::aelr_state_t state_r, state_nxt;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aelr_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    accept    = 1'b0;
    case (state_r)
      aelr_pkg::S_LOAD, aelr_pkg::S_READ: begin
        in_tready = !sts.out_busy;
        accept    = in_tvalid && !sts.out_busy;
        if (accept) begin
          if (in_cmd == aelr_pkg::CMD_LOAD) begin
            cmd.load    = 1'b1;
            cmd.restart = (state_r == aelr_pkg::S_READ);
            state_nxt   = in_final ? aelr_pkg::S_SCAN_RD : aelr_pkg::S_LOAD;
          end else if (state_r == aelr_pkg::S_READ) begin
            state_nxt = aelr_pkg::S_RD_FIND;
          end else begin
            cmd.out_empty = 1'b1;
          end
        end
      end
      aelr_pkg::S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        if (sts.fault) begin
          state_nxt = aelr_pkg::S_REPORT;
        end else if (sts.more) begin
          state_nxt = aelr_pkg::S_SCAN_EV;
        end else begin
          state_nxt = aelr_pkg::S_SCAN_END;
        end
      end
      aelr_pkg::S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = aelr_pkg::S_SCAN_RD;
      end
      aelr_pkg::S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_nxt    = aelr_pkg::S_REPORT;
      end
      aelr_pkg::S_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = sts.ok ? aelr_pkg::S_READ : aelr_pkg::S_LOAD;
      end
      aelr_pkg::S_RD_FIND: begin
        if (sts.ent_ok) begin
          state_nxt = aelr_pkg::S_RD_EMIT;
        end else if (sts.ent_end) begin
          if (sts.pass) begin
            cmd.out_empty = 1'b1;
            state_nxt     = aelr_pkg::S_LOAD;
          end else begin
            cmd.rd_wrap = 1'b1;
          end
        end else begin
          state_nxt = aelr_pkg::S_RD_CHK;
        end
      end
      aelr_pkg::S_RD_CHK: begin
        cmd.rd_chk = 1'b1;
        state_nxt  = aelr_pkg::S_RD_FIND;
      end
      aelr_pkg::S_RD_EMIT: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = sts.last ? aelr_pkg::S_LOAD : aelr_pkg::S_READ;
      end
      default: begin
        state_nxt = aelr_pkg::S_LOAD;
      end
    endcase
  end

endmodule

>>> hw/rtl/aelr_dp.sv
// ----------------------------------------------------------------------------
// aelr_dp
// Datapath: byte store, unit table, start-code scan, readout and result reg.
// ----------------------------------------------------------------------------
module aelr_dp #(
  parameter int UNIT_BYTES = 65536,
  parameter int MAX_UNITS  = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  aelr_pkg::aelr_cmd_t cmd,
  output aelr_pkg::aelr_sts_t sts,
  input  logic [7:0]          in_data,
  input  logic                in_final,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [1:0]          out_status,
  output logic [7:0]          out_byte,
  output logic                out_bvalid,
  output logic                out_final,
  output logic [8:0]          out_wc,
  output logic [8:0]          out_rc,
  output logic [16:0]         out_len
);

  localparam int AW = $clog2(UNIT_BYTES);
  localparam int LW = AW + 1;
  localparam int UW = $clog2(MAX_UNITS);
  localparam int NW = UW + 1;
  localparam int TW = ((LW > 17) ? LW : 17) + 1;
  localparam int EW = 1 + LW + AW;

  // configuration
  logic [5:0] drop_r, rpu_r;
  logic [7:0] wh1_r, wh2_r;

  // load
  logic [LW-1:0] loaded_r, size_r;
  logic          ovf_r;
  logic [LW-1:0] ld_idx;
  logic          ld_ovf, ld_room;

  // scan
  logic [LW-1:0] pos_r, ucnt_r, ds_r;
  logic [1:0]    zrun_r;
  logic          in_unit_r, tid_ok_r;
  logic [5:0]    utype_r;
  logic [TW-1:0] total_r;
  logic [8:0]    wc_r, rc_r;
  logic [NW-1:0] ntot_r;
  logic [1:0]    status_r;
  logic          fault_r;

  // readout
  logic [NW-1:0] rent_r;
  logic [LW-1:0] roff_r, elen_r;
  logic          pass_r, ent_ok_r, ecls_r;
  logic [AW-1:0] ebeg_r;
  logic [16:0]   remain_r;

  // output register
  logic        ov_r, okind_r, obval_r, ofin_r;
  logic [1:0]  ost_r;
  logic [7:0]  obyte_r;
  logic [8:0]  owc_r, orc_r;
  logic [16:0] olen_r;

  // memories
  logic [7:0]    store_q;
  logic [AW-1:0] store_ra;
  logic [EW-1:0] tab_q;
  logic          tab_we;

  // scan combinational
  logic          is_code, close_now, is_rpu, is_drop, commit;
  logic [LW-1:0] close_len;
  logic [TW-1:0] total_n;
  logic          close_bad;
  logic [1:0]    close_st;
  logic [8:0]    wc_n, rc_n;

  // readout combinational
  logic [LW-1:0] head_l, off_n, rd_rel;
  logic [LW:0]   ent_span;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rd_byte;
  logic          t_cls;
  logic [LW-1:0] t_len;
  logic [AW-1:0] t_beg;

  assign ld_idx  = cmd.restart ? '0 : loaded_r;
  assign ld_ovf  = cmd.restart ? 1'b0 : ovf_r;
  assign ld_room = ld_idx < LW'(UNIT_BYTES);

  assign store_ra = cmd.scan_rd ? pos_r[AW-1:0] : rd_idx;

  aelr_ram #(.WIDTH(8), .DEPTH(UNIT_BYTES)) u_store (
    .clk   (clk),
    .we    (cmd.load && ld_room),
    .waddr (ld_idx[AW-1:0]),
    .wdata (in_data),
    .raddr (store_ra),
    .rdata (store_q)
  );

  aelr_ram #(.WIDTH(EW), .DEPTH(MAX_UNITS)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (ntot_r[UW-1:0]),
    .wdata ({is_rpu, close_len, ds_r[AW-1:0]}),
    .raddr (rent_r[UW-1:0]),
    .rdata (tab_q)
  );

  assign t_cls = tab_q[EW-1];
  assign t_len = tab_q[EW-2 -: LW];
  assign t_beg = tab_q[AW-1:0];

  // unit close check, shared by mid-stream codes and end of stream
  always_comb begin
    is_code   = cmd.scan_ev && (store_q == 8'd1) && (zrun_r >= 2'd2);
    close_now = in_unit_r && (is_code || cmd.scan_end);
    close_len = cmd.scan_end ? ucnt_r
                             : ucnt_r - ((zrun_r == 2'd3) ? LW'(3) : LW'(2));
    is_rpu    = (utype_r == rpu_r);
    is_drop   = (utype_r == drop_r);
    total_n   = total_r + TW'(close_len) + (is_rpu ? TW'(4) : TW'(6));
    close_bad = 1'b1;
    close_st  = aelr_pkg::ST_VALID;
    if (close_len < LW'(2) || !tid_ok_r) begin
      close_st = aelr_pkg::ST_MALFORMED;
    end else if (is_drop) begin
      close_bad = 1'b0;
    end else if (total_n > TW'(aelr_pkg::OUT_LEN_MAX) || ntot_r >= NW'(MAX_UNITS)) begin
      close_st = aelr_pkg::ST_OVERSIZED;
    end else if ((is_rpu ? rc_r : wc_r) >= aelr_pkg::COUNT_MAX) begin
      close_st = aelr_pkg::ST_OVERSIZED;
    end else begin
      close_bad = 1'b0;
    end
    commit = close_now && !close_bad && !is_drop;
    tab_we = commit;
    wc_n   = wc_r + 9'((commit && !is_rpu) ? 1 : 0);
    rc_n   = rc_r + 9'((commit && is_rpu) ? 1 : 0);
  end

  always_comb begin
    head_l   = ecls_r ? LW'(4) : LW'(6);
    rd_rel   = roff_r - head_l;
    rd_idx   = AW'(LW'(ebeg_r) + rd_rel);
    off_n    = roff_r + LW'(1);
    ent_span = (LW+1)'(head_l) + (LW+1)'(elen_r);
    if (roff_r < LW'(3)) begin
      rd_byte = 8'd0;
    end else if (roff_r == LW'(3)) begin
      rd_byte = 8'd1;
    end else if (roff_r < head_l) begin
      rd_byte = (roff_r == LW'(4)) ? wh1_r : wh2_r;
    end else begin
      rd_byte = store_q;
    end
  end

  always_comb begin
    sts.fault    = fault_r;
    sts.more     = pos_r < size_r;
    sts.ok       = (status_r == aelr_pkg::ST_VALID);
    sts.ent_ok   = ent_ok_r;
    sts.ent_end  = rent_r >= ntot_r;
    sts.pass     = pass_r;
    sts.last     = (remain_r == 17'd1);
    sts.out_busy = ov_r;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= aelr_pkg::DROP_TYPE_RST;
      rpu_r  <= aelr_pkg::RPU_TYPE_RST;
      wh1_r  <= aelr_pkg::WRAP_FIRST_RST;
      wh2_r  <= aelr_pkg::WRAP_SECND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aelr_pkg::REG_DROP_TYPE:  drop_r <= cfg_data[5:0];
        aelr_pkg::REG_RPU_TYPE:   rpu_r  <= cfg_data[5:0];
        aelr_pkg::REG_WRAP_FIRST: wh1_r  <= cfg_data;
        aelr_pkg::REG_WRAP_SECND: wh2_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // load and scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      ovf_r    <= 1'b0;
      fault_r  <= 1'b0;
      status_r <= aelr_pkg::ST_VALID;
    end else if (cmd.load) begin
      if (in_final) begin
        loaded_r  <= '0;
        ovf_r     <= 1'b0;
        size_r    <= ld_room ? ld_idx + LW'(1) : ld_idx;
        fault_r   <= ld_ovf || !ld_room;
        status_r  <= (ld_ovf || !ld_room) ? aelr_pkg::ST_OVERSIZED : aelr_pkg::ST_VALID;
        pos_r     <= '0;
        zrun_r    <= 2'd0;
        in_unit_r <= 1'b0;
        ucnt_r    <= '0;
        total_r   <= '0;
        wc_r      <= '0;
        rc_r      <= '0;
        ntot_r    <= '0;
      end else begin
        loaded_r <= ld_room ? ld_idx + LW'(1) : ld_idx;
        ovf_r    <= ld_ovf || !ld_room;
      end
    end else if (cmd.scan_ev) begin
      pos_r <= pos_r + LW'(1);
      if (is_code) begin
        // data of the next unit begins right after the 01
        if (close_now && close_bad) begin
          fault_r  <= 1'b1;
          status_r <= close_st;
        end
        in_unit_r <= 1'b1;
        ds_r      <= pos_r + LW'(1);
        ucnt_r    <= '0;
        zrun_r    <= 2'd0;
        if (commit) begin
          total_r <= total_n;
          ntot_r  <= ntot_r + NW'(1);
          wc_r    <= wc_n;
          rc_r    <= rc_n;
        end
      end else if (!in_unit_r && store_q != 8'd0) begin
        // junk ahead of the first start code
        fault_r  <= 1'b1;
        status_r <= aelr_pkg::ST_MALFORMED;
      end else begin
        if (store_q == 8'd0) begin
          zrun_r <= (zrun_r == 2'd3) ? 2'd3 : zrun_r + 2'd1;
        end else begin
          zrun_r <= 2'd0;
        end
        if (in_unit_r) begin
          if (ucnt_r == LW'(0)) begin
            utype_r <= store_q[6:1];
          end
          if (ucnt_r == LW'(1)) begin
            tid_ok_r <= (store_q[2:0] & aelr_pkg::TID_MASK) != 3'd0;
          end
          ucnt_r <= ucnt_r + LW'(1);
        end
      end
    end else if (cmd.scan_end) begin
      fault_r <= 1'b1;
      if (!in_unit_r) begin
        status_r <= aelr_pkg::ST_MALFORMED;
      end else if (close_bad) begin
        status_r <= close_st;
      end else if (wc_n == 9'd0 || rc_n == 9'd0) begin
        status_r <= aelr_pkg::ST_MALFORMED;
      end else begin
        status_r <= aelr_pkg::ST_VALID;
        total_r  <= commit ? total_n : total_r;
        ntot_r   <= ntot_r + NW'(commit ? 1 : 0);
        wc_r     <= wc_n;
        rc_r     <= rc_n;
      end
    end
  end

  // readout walk
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      rent_r   <= '0;
      roff_r   <= '0;
      pass_r   <= 1'b0;
      ent_ok_r <= 1'b0;
      remain_r <= total_r[16:0];
    end else if (cmd.rd_wrap) begin
      pass_r <= 1'b1;
      rent_r <= '0;
    end else if (cmd.rd_chk) begin
      if (t_cls == pass_r) begin
        ent_ok_r <= 1'b1;
        ecls_r   <= t_cls;
        elen_r   <= t_len;
        ebeg_r   <= t_beg;
      end else begin
        rent_r <= rent_r + NW'(1);
      end
    end else if (cmd.rd_emit) begin
      remain_r <= remain_r - 17'd1;
      if ((LW+1)'(off_n) >= ent_span) begin
        rent_r   <= rent_r + NW'(1);
        roff_r   <= '0;
        ent_ok_r <= 1'b0;
      end else begin
        roff_r <= off_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.report) begin
      ov_r    <= 1'b1;
      okind_r <= aelr_pkg::KIND_STATUS;
      ost_r   <= status_r;
      obyte_r <= 8'd0;
      obval_r <= 1'b0;
      ofin_r  <= 1'b0;
      if (status_r == aelr_pkg::ST_VALID) begin
        owc_r  <= wc_r;
        orc_r  <= rc_r;
        olen_r <= total_r[16:0];
      end else begin
        owc_r  <= '0;
        orc_r  <= '0;
        olen_r <= '0;
      end
    end else if (cmd.rd_emit || cmd.out_empty) begin
      ov_r    <= 1'b1;
      okind_r <= aelr_pkg::KIND_BYTE;
      ost_r   <= aelr_pkg::ST_VALID;
      obyte_r <= cmd.rd_emit ? rd_byte : 8'd0;
      obval_r <= cmd.rd_emit;
      ofin_r  <= cmd.rd_emit && sts.last;
      owc_r   <= '0;
      orc_r   <= '0;
      olen_r  <= '0;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_valid  = ov_r;
  assign out_kind   = okind_r;
  assign out_status = ost_r;
  assign out_byte   = obyte_r;
  assign out_bvalid = obval_r;
  assign out_final  = ofin_r;
  assign out_wc     = owc_r;
  assign out_rc     = orc_r;
  assign out_len    = olen_r;

endmodule

>>> hw/rtl/annexb_enhancement_layer_rewrap.sv
// ----------------------------------------------------------------------------
// annexb_enhancement_layer_rewrap
// Splits one stored enhancement-layer access unit at start codes and reads it
// back rewrapped, ordinary units first, parameter-set units last.
// ----------------------------------------------------------------------------
// Load transactions take one byte per cycle into the byte store while no
// result waits in the output register. The transaction that carries tlast
// starts a start-code scan of the stored unit, one store read and one
// evaluate step per byte, followed by a step to close the last unit and a
// step to post the status. Each read transaction then yields one output
// byte in the output register; when a new unit starts, the table walk
// reads and checks table entries in turn, and wraps once to turn to the
// parameter-set units. The single store read port serializes scan and
// readout, and the block takes one transaction at a time, holding in_tready
// low while a result waits in the output register.
module annexb_enhancement_layer_rewrap #(
  parameter int UNIT_BYTES = 65536,
  parameter int MAX_UNITS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // cmd
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] status, [9:2] out_byte, [10] byte_valid,
                                  // [19:11] wrapped_count, [28:20] rpu_count,
                                  // [45:29] out_length, [47:46] zero
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // out_final
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  aelr_pkg::aelr_cmd_t cmd;
  aelr_pkg::aelr_sts_t sts;
  logic [1:0]  o_status;
  logic [7:0]  o_byte;
  logic        o_bvalid;
  logic [8:0]  o_wc, o_rc;
  logic [16:0] o_len;

  aelr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_final  (in_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

  aelr_dp #(.UNIT_BYTES(UNIT_BYTES), .MAX_UNITS(MAX_UNITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_tdata),
    .in_final   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_status (o_status),
    .out_byte   (o_byte),
    .out_bvalid (o_bvalid),
    .out_final  (out_tlast),
    .out_wc     (o_wc),
    .out_rc     (o_rc),
    .out_len    (o_len)
  );

  assign out_tdata = {2'b00, o_len, o_rc, o_wc, o_bvalid, o_byte, o_status};

endmodule

>>> hw/rtl/aelr_chk.sv
// ----------------------------------------------------------------------------
// aelr_chk
// Port-level checks for the rewrapper, bound to the top level.
// ----------------------------------------------------------------------------
module aelr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // one transaction in flight: never ready while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // empty read result carries nothing
  a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && !out_tdata[10] |-> !out_tlast && out_tdata[9:2] == 8'd0)
    else $error("empty byte result not clean");

  // failed parse reports no counts
  a_fail_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[1:0] != 2'd0 |-> out_tdata[45:11] == '0)
    else $error("failed status carries counts");

endmodule

bind annexb_enhancement_layer_rewrap aelr_chk u_aelr_chk (.*);
